FILE: rtl/qjde_pkg.sv
// Shared types, constants and saturating helpers of the quaternion Julia distance estimator.
`default_nettype none
package qjde_pkg;

	localparam int MAX_ITERATIONS_DEF = 16;
	localparam int FRAC_BITS_DEF      = 16;

	localparam int COORD_W = 32;
	localparam int TRAP_W  = 31;
	localparam int WIDE_W  = 64;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 35;
	localparam int PADDR_W = 5;

	localparam logic [31:0] LN2_Q30  = 32'd744261118;
	localparam logic [30:0] TRAP_MAX = 31'h7FFF_FFFF;

	localparam logic [2:0] REG_BAILOUT = 3'd0;
	localparam logic [2:0] REG_LIMIT   = 3'd1;
	localparam logic [2:0] REG_CREAL   = 3'd2;
	localparam logic [2:0] REG_CI      = 3'd3;
	localparam logic [2:0] REG_CJ      = 3'd4;
	localparam logic [2:0] REG_CK      = 3'd5;
	localparam logic [2:0] REG_SLICE   = 3'd6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [TRAP_W-1:0] trap_t;

	// One word handed along the square-root chain.
	typedef struct packed {
		logic              vld;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [WIDE_W-1:0] rad;
	} sqrt_word_t;

	function automatic logic [31:0] mag32(input coord_t v);
		logic [31:0] u;
		u = v;
		return v[31] ? (~u + 32'd1) : u;
	endfunction

	function automatic coord_t sat32(input logic neg, input logic [63:0] mag);
		logic [31:0] m;
		m = mag[31:0];
		if (neg) begin
			if (mag > 64'h8000_0000) return coord_t'(32'h8000_0000);
			return coord_t'(~m + 32'd1);
		end
		if (mag > 64'h7FFF_FFFF) return coord_t'(32'h7FFF_FFFF);
		return coord_t'(m);
	endfunction

	function automatic coord_t add_sat32(input coord_t a, input coord_t b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) return s[32] ? coord_t'(32'h8000_0000) : coord_t'(32'h7FFF_FFFF);
		return coord_t'(s[31:0]);
	endfunction

	function automatic trap_t trap_min(input trap_t t, input coord_t v);
		logic [31:0] m;
		trap_t c;
		m = mag32(v);
		c = m[31] ? TRAP_MAX : m[30:0];
		return (c < t) ? c : t;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/qjde_if.sv
// Stream interfaces for the point word in and the distance word out.
`default_nettype none
interface qjde_in_if;
	import qjde_pkg::*;
	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface qjde_out_if;
	import qjde_pkg::*;
	logic   valid;
	logic   ready;
	coord_t distance;
	trap_t  trap_real;
	trap_t  trap_i;
	trap_t  trap_j;
	modport source (output valid, output distance, output trap_real, output trap_i,
		output trap_j, input ready);
	modport sink (input valid, input distance, input trap_real, input trap_i,
		input trap_j, output ready);
endinterface
`default_nettype wire

FILE: rtl/qjde_sqrt_cell.sv
// One digit cell of the square-root chain: settles one root bit from two radicand bits.
`default_nettype none
module qjde_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  qjde_pkg::sqrt_word_t din,
	output qjde_pkg::sqrt_word_t dout
);
	import qjde_pkg::*;

	logic              vld_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [WIDE_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	assign rem_sh = {din.rem[REM_W-3:0], din.rad[WIDE_W-1:WIDE_W-2]};
	assign trial  = {1'b0, din.root, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= take ? (rem_sh - trial) : rem_sh;
		root_q <= {din.root[ROOT_W-2:0], take};
		rad_q  <= {din.rad[WIDE_W-3:0], 2'b00};
	end

	assign dout = '{vld: vld_q, rem: rem_q, root: root_q, rad: rad_q};
endmodule
`default_nettype wire

FILE: rtl/qjde_sqrt_chain.sv
// Row of digit cells forming a floor square root of a 64-bit radicand.
`default_nettype none
module qjde_sqrt_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          launch,
	input  logic [qjde_pkg::WIDE_W-1:0]   radicand,
	output logic                          done,
	output logic [qjde_pkg::ROOT_W-1:0]   root
);
	import qjde_pkg::*;

	sqrt_word_t link [0:ROOT_W];

	assign link[0] = '{vld: launch, rem: '0, root: '0, rad: radicand};

	for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
		qjde_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[g]),
			.dout   (link[g+1])
		);
	end

	assign done = link[ROOT_W].vld;
	assign root = link[ROOT_W].root;
endmodule
`default_nettype wire

FILE: rtl/qjde_div.sv
// Restoring divider, one quotient bit per cycle, for the final distance quotient.
`default_nettype none
module qjde_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qjde_pkg::WIDE_W-1:0] dividend,
	input  logic [qjde_pkg::WIDE_W-1:0] divisor,
	output logic                        done,
	output logic [qjde_pkg::WIDE_W-1:0] quotient
);
	import qjde_pkg::*;

	localparam int CW = $clog2(WIDE_W + 1);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [WIDE_W:0]   rem_q;
	logic [WIDE_W-1:0] dvd_q;
	logic [WIDE_W-1:0] dvs_q;
	logic [WIDE_W:0]   rem_sh;
	logic              take;

	assign rem_sh = {rem_q[WIDE_W-1:0], dvd_q[WIDE_W-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(WIDE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= take ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dvd_q <= {dvd_q[WIDE_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

FILE: rtl/quaternion_julia_distance_estimate.sv
// Top level of the quaternion Julia set distance estimator.
// Each point word is worked on alone and yields one distance word. A point first finds
// its starting length with four squares and a pass through the 32-cell square-root
// chain. Each iteration then takes five products on the shared 32x32 multiplier, an
// update step, four squares and a pass through the chain. After that come normalisation,
// logarithm squaring, the ln products and the bit-serial divider; a point that ends
// on a zero radius skips all four of these phases, and the divider is bypassed when
// the scaled log term or dr is zero. The result waits in an output register, so the
// next point is taken while it is unread.
`default_nettype none
module quaternion_julia_distance_estimate #(
	parameter int MAX_ITERATIONS = qjde_pkg::MAX_ITERATIONS_DEF,
	parameter int FRAC_BITS      = qjde_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	qjde_in_if.sink                      in_ch,
	qjde_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qjde_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import qjde_pkg::*;

	localparam int ITW = $clog2(MAX_ITERATIONS + 1);
	localparam int LCW = $clog2(FRAC_BITS);
	localparam int DRS = FRAC_BITS - 1;
	localparam logic [63:0] ALL1     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PH_LIMIT = ALL1 >> (32 - DRS);
	localparam logic [63:0] DR_ONE   = 64'd1 << FRAC_BITS;
	localparam logic [30:0] BAIL_RST = 31'd2 << FRAC_BITS;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_SQR   = 10'b00_0000_0010,
		ST_ROOT  = 10'b00_0000_0100,
		ST_CROSS = 10'b00_0000_1000,
		ST_UPD   = 10'b00_0001_0000,
		ST_NORM  = 10'b00_0010_0000,
		ST_LOG   = 10'b00_0100_0000,
		ST_LN    = 10'b00_1000_0000,
		ST_DIV   = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

	// Configuration registers.
	logic [30:0] bail_q;
	logic [6:0]  limit_q;
	coord_t      cre_q, ci_q, cj_q, ck_q, slice_q;

	// Control.
	state_t         state_q;
	logic [2:0]     cnt_q;
	logic [LCW-1:0] lcnt_q;
	logic           first_q;
	logic [ITW-1:0] it_q;
	logic [ITW-1:0] steps_q;
	logic           ovalid_q;

	// Datapath.
	coord_t      z0_q, z1_q, z2_q, z3_q;
	logic [63:0] sq0_q, sq1_q, sq2_q, sq3_q, len2_q;
	logic [63:0] cr1_q, cr2_q, cr3_q, ph_q, pl_q;
	logic [63:0] dr_q, prod_q;
	logic [31:0] r_q, nm_q, lm_q, lnv_q;
	logic [30:0] half_q;
	logic [4:0]  p_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic        nneg_q;
	trap_t       tw_q, tx_q, ty_q;
	coord_t      res_q;
	coord_t      od_q;
	trap_t       otw_q, otx_q, oty_q;

	logic [31:0] mul_a, mul_b;
	logic        in_acc, cfg_wr, out_load;
	logic        root_done, root_fin;
	logic [31:0] root_val;
	logic [ITW-1:0] it_nx;
	logic [ITW-1:0] steps_c;
	logic [64:0] len_acc;
	logic [63:0] rest, dd, pk1, pk2, pk3, dr_a, dr_b, dr_new;
	logic [64:0] dr_sum;
	logic        w_ge;
	coord_t      nz0, nz1, nz2, nz3;
	logic [31:0] lbits, lmag;
	logic [31:0] m2;
	logic [63:0] nmag_c;
	logic        div_start, div_done;
	logic [63:0] div_q;
	logic [30:0] q_cl;
	logic [31:0] q_ext;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid & in_ch.ready;
	assign out_load = (state_q == ST_DONE) && (!ovalid_q || out_ch.ready);

	always_comb begin
		case (paddr[4:2])
			REG_BAILOUT: prdata = {1'b0, bail_q};
			REG_LIMIT:   prdata = {25'd0, limit_q};
			REG_CREAL:   prdata = cre_q;
			REG_CI:      prdata = ci_q;
			REG_CJ:      prdata = cj_q;
			REG_CK:      prdata = ck_q;
			REG_SLICE:   prdata = slice_q;
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bail_q  <= BAIL_RST;
			limit_q <= 7'd16;
			cre_q   <= '0;
			ci_q    <= '0;
			cj_q    <= '0;
			ck_q    <= '0;
			slice_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_BAILOUT: bail_q  <= pwdata[30:0];
				REG_LIMIT:   limit_q <= pwdata[6:0];
				REG_CREAL:   cre_q   <= pwdata;
				REG_CI:      ci_q    <= pwdata;
				REG_CJ:      cj_q    <= pwdata;
				REG_CK:      ck_q    <= pwdata;
				REG_SLICE:   slice_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Shared multiplier; the product is registered, ready in the cycle after its operands are set.
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_SQR: begin
				case (cnt_q)
					3'd0: begin mul_a = mag32(z0_q); mul_b = mag32(z0_q); end
					3'd1: begin mul_a = mag32(z1_q); mul_b = mag32(z1_q); end
					3'd2: begin mul_a = mag32(z2_q); mul_b = mag32(z2_q); end
					3'd3: begin mul_a = mag32(z3_q); mul_b = mag32(z3_q); end
					default: ;
				endcase
			end
			ST_CROSS: begin
				case (cnt_q)
					3'd0: begin mul_a = mag32(z0_q); mul_b = mag32(z1_q); end
					3'd1: begin mul_a = mag32(z0_q); mul_b = mag32(z2_q); end
					3'd2: begin mul_a = mag32(z0_q); mul_b = mag32(z3_q); end
					3'd3: begin mul_a = r_q; mul_b = dr_q[63:32]; end
					3'd4: begin mul_a = r_q; mul_b = dr_q[31:0]; end
					default: ;
				endcase
			end
			ST_LOG: begin
				mul_a = lm_q;
				mul_b = lm_q;
			end
			ST_LN: begin
				case (cnt_q)
					3'd0: begin mul_a = lmag; mul_b = LN2_Q30; end
					3'd2: begin mul_a = lnv_q; mul_b = r_q; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	qjde_sqrt_chain u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   ((state_q == ST_ROOT) && (cnt_q == 3'd0)),
		.radicand (len2_q),
		.done     (root_done),
		.root     (root_val)
	);

	assign div_start = (state_q == ST_LN) && (cnt_q == 3'd3) && (nmag_c != 64'd0)
		&& (dr_q != 64'd0);

	qjde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nmag_c << FRAC_BITS),
		.divisor  (dr_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		steps_c = (limit_q < 7'(MAX_ITERATIONS)) ? ITW'(limit_q) : ITW'(MAX_ITERATIONS);
		it_nx   = it_q + ITW'(1);
		if (first_q) begin
			root_fin = (steps_q == '0);
		end else begin
			root_fin = (root_val > {1'b0, bail_q}) || (it_nx == steps_q);
		end

		len_acc = {1'b0, len2_q} + {1'b0, prod_q};

		// Squaring of the quaternion, then the constant is added with saturation.
		rest = sq1_q + sq2_q + sq3_q;
		w_ge = sq0_q >= rest;
		dd   = w_ge ? (sq0_q - rest) : (rest - sq0_q);
		nz0  = sat32(!w_ge, dd >> FRAC_BITS);
		pk1  = cr1_q >> DRS;
		pk2  = cr2_q >> DRS;
		pk3  = cr3_q >> DRS;
		nz1  = sat32((z0_q[31] ^ z1_q[31]) && (pk1 != 64'd0), pk1);
		nz2  = sat32((z0_q[31] ^ z2_q[31]) && (pk2 != 64'd0), pk2);
		nz3  = sat32((z0_q[31] ^ z3_q[31]) && (pk3 != 64'd0), pk3);

		dr_a   = ph_q << (32 - DRS);
		dr_b   = pl_q >> DRS;
		dr_sum = {1'b0, dr_a} + {1'b0, dr_b};
		dr_new = (ph_q > PH_LIMIT || dr_sum[64]) ? ALL1 : dr_sum[63:0];

		lbits = ((32'(p_q) - 32'(FRAC_BITS)) << FRAC_BITS) + 32'(frac_q);
		lmag  = lbits[31] ? (~lbits + 32'd1) : lbits;
		m2    = prod_q[61:30];

		nmag_c = prod_q >> (FRAC_BITS + 1);

		q_cl  = (div_q > {33'd0, half_q}) ? half_q : div_q[30:0];
		q_ext = {1'b0, q_cl};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= 3'd0;
			lcnt_q   <= '0;
			first_q  <= 1'b0;
			it_q     <= '0;
			steps_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SQR;
						cnt_q   <= 3'd0;
						first_q <= 1'b1;
						it_q    <= '0;
						steps_q <= steps_c;
					end
				end
				ST_SQR: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= ST_ROOT;
						cnt_q   <= 3'd0;
					end
				end
				ST_ROOT: begin
					if (cnt_q == 3'd0) begin
						cnt_q <= 3'd1;
					end else if (root_done) begin
						first_q <= 1'b0;
						cnt_q   <= 3'd0;
						if (!first_q) it_q <= it_nx;
						if (!root_fin) state_q <= ST_CROSS;
						else if (root_val == 32'd0) state_q <= ST_DONE;
						else state_q <= ST_NORM;
					end
				end
				ST_CROSS: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) begin
						state_q <= ST_UPD;
						cnt_q   <= 3'd0;
					end
				end
				ST_UPD: begin
					state_q <= ST_SQR;
				end
				ST_NORM: begin
					if (nm_q[31]) begin
						state_q <= ST_LOG;
						cnt_q   <= 3'd0;
						lcnt_q  <= '0;
					end
				end
				ST_LOG: begin
					if (cnt_q == 3'd0) begin
						cnt_q <= 3'd1;
					end else begin
						cnt_q  <= 3'd0;
						lcnt_q <= lcnt_q + LCW'(1);
						if (lcnt_q == LCW'(FRAC_BITS - 1)) state_q <= ST_LN;
					end
				end
				ST_LN: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						cnt_q   <= 3'd0;
						state_q <= div_start ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q  <= ST_IDLE;
						ovalid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					z0_q <= in_ch.pos_x;
					z1_q <= in_ch.pos_y;
					z2_q <= in_ch.pos_z;
					z3_q <= slice_q;
					dr_q <= DR_ONE;
					tw_q <= TRAP_MAX;
					tx_q <= TRAP_MAX;
					ty_q <= TRAP_MAX;
				end
			end
			ST_SQR: begin
				// The traps follow each freshly updated quaternion.
				if (cnt_q == 3'd0 && !first_q) begin
					tw_q <= trap_min(tw_q, z0_q);
					tx_q <= trap_min(tx_q, z1_q);
					ty_q <= trap_min(ty_q, z2_q);
				end
				case (cnt_q)
					3'd1: begin sq0_q <= prod_q; len2_q <= prod_q; end
					3'd2: begin sq1_q <= prod_q; len2_q <= len_acc[63:0]; end
					3'd3: begin sq2_q <= prod_q; len2_q <= len_acc[63:0]; end
					3'd4: begin
						sq3_q  <= prod_q;
						len2_q <= len_acc[64] ? ALL1 : len_acc[63:0];
					end
					default: ;
				endcase
			end
			ST_ROOT: begin
				if (cnt_q != 3'd0 && root_done) begin
					r_q   <= root_val;
					nm_q  <= root_val;
					p_q   <= 5'd31;
					res_q <= '0;
					if (first_q) half_q <= root_val[31:1];
				end
			end
			ST_CROSS: begin
				case (cnt_q)
					3'd1: cr1_q <= prod_q;
					3'd2: cr2_q <= prod_q;
					3'd3: cr3_q <= prod_q;
					3'd4: ph_q  <= prod_q;
					3'd5: pl_q  <= prod_q;
					default: ;
				endcase
			end
			ST_UPD: begin
				z0_q <= add_sat32(nz0, cre_q);
				z1_q <= add_sat32(nz1, ci_q);
				z2_q <= add_sat32(nz2, cj_q);
				z3_q <= add_sat32(nz3, ck_q);
				dr_q <= dr_new;
			end
			ST_NORM: begin
				if (nm_q[31]) begin
					lm_q   <= {1'b0, nm_q[31:1]};
					frac_q <= '0;
				end else begin
					nm_q <= {nm_q[30:0], 1'b0};
					p_q  <= p_q - 5'd1;
				end
			end
			ST_LOG: begin
				if (cnt_q != 3'd0) begin
					lm_q   <= m2[31] ? {1'b0, m2[31:1]} : m2;
					frac_q <= {frac_q[FRAC_BITS-2:0], m2[31]};
				end
			end
			ST_LN: begin
				case (cnt_q)
					3'd1: lnv_q <= prod_q[61:30];
					3'd3: begin
						nneg_q <= lbits[31] && (nmag_c != 64'd0);
						if (nmag_c == 64'd0) begin
							res_q <= '0;
						end else if (dr_q == 64'd0) begin
							res_q <= lbits[31] ? coord_t'(~{1'b0, half_q} + 32'd1)
								: coord_t'({1'b0, half_q});
						end
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				if (div_done) res_q <= nneg_q ? coord_t'(~q_ext + 32'd1) : coord_t'(q_ext);
			end
			ST_DONE: begin
				if (out_load) begin
					od_q  <= res_q;
					otw_q <= tw_q;
					otx_q <= tx_q;
					oty_q <= ty_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.distance  = od_q;
	assign out_ch.trap_real = otw_q;
	assign out_ch.trap_i    = otx_q;
	assign out_ch.trap_j    = oty_q;
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for the quaternion Julia distance estimator, with its own fixed-point model.
`default_nettype none
module tb;
	import qjde_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int MAXIT = MAX_ITERATIONS_DEF;
	localparam longint unsigned ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint unsigned M32 = 64'hFFFF_FFFF;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct {
		coord_t distance;
		trap_t  tr;
		trap_t  ti;
		trap_t  tj;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	qjde_in_if pts ();
	qjde_out_if res ();

	quaternion_julia_distance_estimate DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(pts), .out_ch(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model copy of the registers.
	logic [30:0] bail = 31'd131072;
	logic [6:0]  lim = 7'd16;
	longint      cq [4] = '{0, 0, 0, 0};
	longint      slice = 0;

	point_t    pend [$];
	estimate_t expected_q [$];
	bit        failed = 1'b0;

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint clip32(bit neg, longint unsigned m);
		if (neg) return (m > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(m);
		return (m > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(m);
	endfunction

	function automatic longint add_clip(longint a, longint b);
		longint s;
		s = a + b;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned len_sq(longint q [4]);
		longint unsigned s, t;
		s = magn(q[0]) * magn(q[0]) + magn(q[1]) * magn(q[1]) + magn(q[2]) * magn(q[2]);
		t = magn(q[3]) * magn(q[3]);
		return (s > ALL1 - t) ? ALL1 : s + t;
	endfunction

	function automatic longint unsigned grow_dr(longint unsigned r, longint unsigned dr);
		longint unsigned ph, pl, a, b;
		ph = r * (dr >> 32);
		pl = r * (dr & M32);
		if (ph > (ALL1 >> (33 - FB))) return ALL1;
		a = ph << (33 - FB);
		b = pl >> (FB - 1);
		return (a > ALL1 - b) ? ALL1 : a + b;
	endfunction

	function automatic longint log2_fixed(longint unsigned r);
		int p;
		longint unsigned m, frac;
		p = 63;
		frac = 0;
		while (p > 0 && r[p] == 1'b0) p--;
		m = (p <= 30) ? (r << (30 - p)) : (r >> (p - 30));
		for (int i = 0; i < FB; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		return longint'(p - FB) * (longint'(1) << FB) + longint'(frac);
	endfunction

	function automatic longint unsigned trap_upd(longint unsigned t, longint v);
		longint unsigned a;
		a = magn(v);
		if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
		return a < t ? a : t;
	endfunction

	function automatic estimate_t estimate(point_t pt);
		longint z [4], nz [4];
		longint unsigned r, r0, half, dr, tw, tx, ty, steps, nmag, q, w2, rest, p, lnv;
		longint l;
		bit nneg;
		estimate_t e;
		z[0] = pt.x; z[1] = pt.y; z[2] = pt.z; z[3] = slice;
		dr = 64'd1 << FB;
		tw = 64'h7FFF_FFFF; tx = tw; ty = tw;
		nmag = 0;
		nneg = 1'b0;
		steps = (lim < MAXIT) ? lim : MAXIT;
		r0 = root_floor(len_sq(z));
		half = r0 >> 1;
		r = r0;
		for (longint unsigned i = 0; i < steps; i++) begin
			w2 = magn(z[0]) * magn(z[0]);
			rest = magn(z[1]) * magn(z[1]) + magn(z[2]) * magn(z[2]) + magn(z[3]) * magn(z[3]);
			dr = grow_dr(r, dr);
			nz[0] = (w2 >= rest) ? clip32(1'b0, (w2 - rest) >> FB) : clip32(1'b1, (rest - w2) >> FB);
			for (int k = 1; k < 4; k++) begin
				p = (magn(z[0]) * magn(z[k])) >> (FB - 1);
				nz[k] = clip32(((z[0] < 0) != (z[k] < 0)) && p != 0, p);
			end
			for (int k = 0; k < 4; k++) z[k] = add_clip(nz[k], cq[k]);
			r = root_floor(len_sq(z));
			tw = trap_upd(tw, z[0]);
			tx = trap_upd(tx, z[1]);
			ty = trap_upd(ty, z[2]);
			if (r > bail) break;
		end
		if (r != 0) begin
			l = log2_fixed(r);
			lnv = (magn(l) * 64'd744261118) >> 30;
			nmag = (lnv * r) >> (FB + 1);
			nneg = l < 0 && nmag != 0;
		end
		if (nmag == 0) q = 0;
		else if (dr == 0) q = half;
		else begin
			q = (nmag << FB) / dr;
			if (q > half) q = half;
		end
		e.distance = coord_t'(nneg ? -longint'(q) : longint'(q));
		e.tr = tw[30:0];
		e.ti = tx[30:0];
		e.tj = ty[30:0];
		return e;
	endfunction

	// Sender: bursts of words separated by random gaps; a presented word is held until taken.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts.valid <= 1'b0;
			pts.pos_x <= '0;
			pts.pos_y <= '0;
			pts.pos_z <= '0;
		end else if (pts.valid && !pts.ready) begin
			pts.valid <= 1'b1;
		end else begin
			if (pts.valid) begin
				expected_q.push_back(estimate(pend[0]));
				void'(pend.pop_front());
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				pts.valid <= 1'b0;
			end else if (pend.size() > 0) begin
				pts.valid <= 1'b1;
				pts.pos_x <= pend[0].x;
				pts.pos_y <= pend[0].y;
				pts.pos_z <= pend[0].z;
			end else begin
				pts.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern switches between always ready, random, sparse and periodic.
	int stall_mode = 0;
	int mode_left = 0;
	int cyc = 0;
	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$error("distance word with no point outstanding");
					failed = 1'b1;
				end else begin
					e = expected_q.pop_front();
					if (res.distance !== e.distance) begin
						$error("distance: expected %0d, got %0d", e.distance, res.distance);
						failed = 1'b1;
					end
					if (res.trap_real !== e.tr) begin
						$error("trap_real: expected %0h, got %0h", e.tr, res.trap_real);
						failed = 1'b1;
					end
					if (res.trap_i !== e.ti) begin
						$error("trap_i: expected %0h, got %0h", e.ti, res.trap_i);
						failed = 1'b1;
					end
					if (res.trap_j !== e.tj) begin
						$error("trap_j: expected %0h, got %0h", e.tj, res.trap_j);
						failed = 1'b1;
					end
				end
			end
			cyc++;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(64, 600);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= $urandom_range(0, 1);
				2: res.ready <= ($urandom_range(0, 7) == 0);
				default: res.ready <= (cyc % 5 != 0);
			endcase
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BAILOUT: bail = v[30:0];
			REG_LIMIT:   lim = v[6:0];
			REG_CREAL:   cq[0] = longint'(signed'(v));
			REG_CI:      cq[1] = longint'(signed'(v));
			REG_CJ:      cq[2] = longint'(signed'(v));
			REG_CK:      cq[3] = longint'(signed'(v));
			REG_SLICE:   slice = longint'(signed'(v));
			default: ;
		endcase
	endtask

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		point_t pt;
		pt.x = x; pt.y = y; pt.z = z;
		pend.push_back(pt);
	endtask

	task automatic drain;
		while (pend.size() != 0 || expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// Mostly values near the interesting region of about +-2.0, sometimes anything at all.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
			default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
		endcase
	endfunction

	function automatic logic [31:0] rand_const();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
		endcase
	endfunction

	initial begin
		int n;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero point, unit point, extremes of the fields.
		add_point(32'd0, 32'd0, 32'd0);
		add_point(32'h0001_0000, 32'd0, 32'd0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_point(32'h8000_0000, 32'd0, 32'd0);
		add_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000);
		add_point(32'h0002_0000, 32'd0, 32'd0);
		add_point(32'd1, 32'hFFFF_FFFF, 32'd0);
		drain();

		// No step at all, then a step count past the build maximum.
		cfg_write(REG_LIMIT, 32'hFFFF_FF80);
		add_point(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000);
		add_point(32'd0, 32'd0, 32'd0);
		drain();
		cfg_write(REG_LIMIT, 32'd127);
		add_point(32'h0000_4000, 32'h0000_2000, 32'h0000_1000);
		drain();

		// Zero radius on the first step leaves dr at zero while c pushes the orbit out.
		cfg_write(REG_LIMIT, 32'd2);
		cfg_write(REG_CREAL, 32'h0001_8000);
		add_point(32'd0, 32'd0, 32'd0);
		drain();

		// Strict bailout at zero and at its top, with extreme constants and slice.
		cfg_write(REG_BAILOUT, 32'h8000_0000);
		cfg_write(REG_CI, 32'h8000_0000);
		cfg_write(REG_CJ, 32'h7FFF_FFFF);
		cfg_write(REG_CK, 32'h8000_0000);
		cfg_write(REG_SLICE, 32'h8000_0000);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd5);
		add_point(32'd0, 32'd0, 32'd0);
		drain();
		cfg_write(REG_BAILOUT, 32'hFFFF_FFFF);
		cfg_write(3'd7, 32'h1234_5678);
		add_point(32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800);
		add_point(32'hC000_0000, 32'h4000_0000, 32'h8000_0001);
		drain();

		// Random phases with fresh settings; the last runs the full step count.
		for (int ph = 0; ph < 10; ph++) begin
			cfg_write(REG_BAILOUT, ($urandom_range(0, 5) == 0) ? $urandom
				: 32'($urandom_range(1 << 16, 1 << 19)));
			cfg_write(REG_LIMIT, (ph == 9) ? 32'd16 : 32'($urandom_range(1, 5)));
			cfg_write(REG_CREAL, rand_const());
			cfg_write(REG_CI, rand_const());
			cfg_write(REG_CJ, rand_const());
			cfg_write(REG_CK, rand_const());
			cfg_write(REG_SLICE, ($urandom_range(0, 2) == 0) ? 32'd0 : rand_const());
			n = (ph == 9) ? 80 : 190;
			for (int i = 0; i < n; i++) add_point(rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		repeat (200) @(posedge clk);
		if (!failed) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(64'd8 * 64'd8_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: quaternion_julia_distance_estimate.f
rtl/qjde_pkg.sv
rtl/qjde_if.sv
rtl/qjde_sqrt_cell.sv
rtl/qjde_sqrt_chain.sv
rtl/qjde_div.sv
rtl/quaternion_julia_distance_estimate.sv
dv/tb.sv
